>>> hdl/lra_pkg.sv
// Shared types, constants and helper functions of the readout line assembler.
`default_nettype none
package lra_pkg;

   localparam int WORD_W            = 32;
   localparam int WORDS_PER_LINE    = 8;
   localparam int LINES_PER_PACKET  = 5;
   localparam int STORED_LINES      = LINES_PER_PACKET - 1;
   localparam int CHANNELS_PER_HALF = 36;
   localparam int BANKS             = 2;
   localparam int ROWS              = BANKS * STORED_LINES;
   localparam int LINE_W            = WORD_W * WORDS_PER_LINE;

   typedef logic [2:0]                              line_idx_type;
   typedef logic [2:0]                              word_idx_type;
   typedef logic [5:0]                              chan_type;
   typedef logic [$clog2(ROWS)-1:0]                 row_addr_type;
   typedef logic [WORDS_PER_LINE-1:0][WORD_W-1:0]   line_type;

   localparam line_idx_type LAST_LINE   = 3'd4;
   localparam chan_type     LAST_CHAN   = 6'd35;
   localparam logic [6:0]   HALF_OFFSET = 7'd36;

   // one completed package handed from the front to the back
   typedef struct packed {
      line_type    words;   // line 4, taken straight from the input
      logic [7:0]  board;
      logic [7:0]  chip;
      logic [31:0] stamp;
      logic        half;
      logic        bank;    // store bank holding lines 0..3
   } job_type;

   // a store bank claimed by the queue or by the back end
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_hold_type;

   // TOT with bit 9 set carries a coarse value: low 9 bits times 8
   function automatic logic [11:0] decode_tot(input logic [9:0] raw);
      logic [11:0] res;
      if (raw[9]) begin
         res = {raw[8:0], 3'b000};
      end else begin
         res = {2'b00, raw};
      end
      return res;
   endfunction

   // header, common mode, calibration and CRC words carry no channel
   function automatic logic skipped_word(input line_idx_type ln, input word_idx_type wd);
      return (ln == 3'd0 && wd == 3'd0) || (ln == 3'd0 && wd == 3'd1) ||
             (ln == 3'd3 && wd == 3'd5) || (ln == LAST_LINE && wd == 3'd7);
   endfunction

endpackage
`default_nettype wire

>>> hdl/lra_if.sv
// Valid/ready channel interfaces for readout lines and channel results.
`default_nettype none
interface lra_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  line_index;
   logic [31:0] word_0;
   logic [31:0] word_1;
   logic [31:0] word_2;
   logic [31:0] word_3;
   logic [31:0] word_4;
   logic [31:0] word_5;
   logic [31:0] word_6;
   logic [31:0] word_7;
   logic [7:0]  board_id;
   logic [7:0]  chip_id;
   logic [32:0] half_and_stamp;

   modport source (output valid, line_index, word_0, word_1, word_2, word_3, word_4,
                   word_5, word_6, word_7, board_id, chip_id, half_and_stamp,
                   input ready);
   modport sink (input valid, line_index, word_0, word_1, word_2, word_3, word_4,
                 word_5, word_6, word_7, board_id, chip_id, half_and_stamp,
                 output ready);
endinterface

interface lra_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  channel_number;
   logic [7:0]  board_out;
   logic [7:0]  chip_out;
   logic [31:0] stamp_out;
   logic [9:0]  adc_value;
   logic [11:0] tot_value;
   logic [9:0]  toa_value;
   logic        last_channel;

   modport source (output valid, channel_number, board_out, chip_out, stamp_out,
                   adc_value, tot_value, toa_value, last_channel,
                   input ready);
   modport sink (input valid, channel_number, board_out, chip_out, stamp_out,
                 adc_value, tot_value, toa_value, last_channel,
                 output ready);
endinterface
`default_nettype wire

>>> hdl/readout_line_assembler_unpacker.sv
// Top level of the readout line assembler and channel unpacker.
//
//   channel | dir | beat                          | accepted when
//   --------+-----+-------------------------------+----------------------------
//   req     | in  | one readout line, 8 words+ids | req.valid && req.ready
//   rsp     | out | one channel result            | rsp.valid && rsp.ready
//
// Flow: the front takes one line per cycle while the queue is empty and its
//   bank is free; the back starts a package with a queue pop and a first row
//   read, then emits a result for each channel word and steps over the
//   calibration word; the package rate is set by the single result port
//   draining 36 results.
// The store holds two banks of lines 0..3; the front fills one bank while
//   the back reads the other, and stalls when its bank is still claimed.
// Reset: synchronous, clears run tracking, queue and back-end state; the
//   line store needs no clearing since a package only reads its own lines.
// Stalls: rsp backpressure holds the back end, and a new package starts only
//   once the last beat of the previous one leaves; a full queue or claimed
//   bank holds req.ready low.
`default_nettype none
module readout_line_assembler_unpacker (
   input  wire logic clock,
   input  wire logic reset,
   lra_req_if.sink   req,
   lra_rsp_if.source rsp
);
   import lra_pkg::*;

   // front to store and queue
   logic          wr_en;
   row_addr_type  wr_addr;
   line_type      wr_data;
   logic          push;
   job_type       push_job;

   // queue to back
   logic          q_valid;
   logic          q_pop;
   job_type       q_job;
   bank_hold_type hold_q;

   // back to store
   logic          rd_en;
   row_addr_type  rd_addr;
   line_type      rd_data;
   bank_hold_type hold_back;

   lra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .hold_q    (hold_q),
      .hold_back (hold_back),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .job       (push_job)
   );

   // one row per stored line, two banks
   lra_ram #(
      .WIDTH (LINE_W),
      .DEPTH (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lra_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (push_job),
      .pop     (q_pop),
      .valid   (q_valid),
      .job_out (q_job),
      .hold    (hold_q)
   );

   lra_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_job),
      .q_pop   (q_pop),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .hold    (hold_back),
      .rsp     (rsp)
   );

   // the bank being written is never the one the back end is reading
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr[$bits(row_addr_type)-1] != rd_addr[$bits(row_addr_type)-1])
      else $error("store write and read hit the same bank");

endmodule
`default_nettype wire

>>> hdl/lra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lra_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hdl/lra_front.sv
// Front end: takes lines, tracks the run, stores lines 0..3, queues packages.
`default_nettype none
module lra_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lra_req_if.sink                    req,
   input  wire lra_pkg::bank_hold_type hold_q,
   input  wire lra_pkg::bank_hold_type hold_back,
   output logic                       wr_en,
   output lra_pkg::row_addr_type      wr_addr,
   output lra_pkg::line_type          wr_data,
   output logic                       push,
   output lra_pkg::job_type           job
);
   import lra_pkg::*;

   typedef enum logic [1:0] {
      LINE_DROP,
      LINE_STORE,
      LINE_BREAK,
      LINE_COMPLETE
   } line_class_type;

   line_idx_type   expected_ff, expected_in;
   logic           bank_ff, bank_in;
   line_class_type cls;
   logic           bank_locked;
   logic           accept;

   always_comb begin
      if (req.line_index > LAST_LINE) begin
         cls = LINE_DROP;
      end else if (req.line_index == 3'd0 ||
                   (req.line_index != LAST_LINE && req.line_index == expected_ff)) begin
         cls = LINE_STORE;
      end else if (req.line_index == LAST_LINE && expected_ff == LAST_LINE) begin
         cls = LINE_COMPLETE;
      end else begin
         cls = LINE_BREAK;
      end
   end

   // the bank being filled must not be one still waiting or being read out
   assign bank_locked = (hold_q.valid && hold_q.bank == bank_ff) ||
                        (hold_back.valid && hold_back.bank == bank_ff);
   assign req.ready   = !bank_locked && !hold_q.valid;
   assign accept      = req.valid && req.ready;

   always_comb begin
      wr_data[0] = req.word_0;
      wr_data[1] = req.word_1;
      wr_data[2] = req.word_2;
      wr_data[3] = req.word_3;
      wr_data[4] = req.word_4;
      wr_data[5] = req.word_5;
      wr_data[6] = req.word_6;
      wr_data[7] = req.word_7;
   end

   assign wr_en   = accept && cls == LINE_STORE;
   assign wr_addr = {bank_ff, req.line_index[1:0]};
   assign push    = accept && cls == LINE_COMPLETE;

   always_comb begin
      job.words = wr_data;
      job.board = req.board_id;
      job.chip  = req.chip_id;
      job.stamp = req.half_and_stamp[31:0];
      job.half  = req.half_and_stamp[32];
      job.bank  = bank_ff;
   end

   always_comb begin
      expected_in = expected_ff;
      bank_in     = bank_ff;
      if (accept) begin
         case (cls)
            LINE_STORE: begin
               expected_in = req.line_index + 3'd1;
            end
            LINE_BREAK: begin
               expected_in = 3'd0;
            end
            LINE_COMPLETE: begin
               expected_in = 3'd0;
               bank_in     = ~bank_ff;
            end
            default: begin
               expected_in = expected_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 3'd0;
         bank_ff     <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         bank_ff     <= bank_in;
      end
   end

   a_drop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && cls == LINE_DROP |=> expected_ff == $past(expected_ff) &&
                                     bank_ff == $past(bank_ff))
      else $error("dropped line changed the run state");

   a_expected_in_range: assert property (@(posedge clock) disable iff (reset)
      push |=> expected_ff == 3'd0 && bank_ff != $past(bank_ff))
      else $error("package completion did not restart the run");

endmodule
`default_nettype wire

>>> hdl/lra_job_queue.sv
// One-entry queue of completed packages between front and back end.
`default_nettype none
module lra_job_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire lra_pkg::job_type       job_in,
   input  wire logic                   pop,
   output logic                        valid,
   output lra_pkg::job_type            job_out,
   output lra_pkg::bank_hold_type      hold
);
   import lra_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff;

   assign valid_in = push || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push) begin
         job_ff <= job_in;
      end
   end

   assign valid      = valid_ff;
   assign job_out    = job_ff;
   assign hold.valid = valid_ff;
   assign hold.bank  = job_ff.bank;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> !valid_ff || pop)
      else $error("package pushed over a waiting one");

endmodule
`default_nettype wire

>>> hdl/lra_back.sv
// Back end: reads lines, emits one channel result per cycle unless rsp stalls.
`default_nettype none
module lra_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire lra_pkg::job_type       q_job,
   output logic                        q_pop,
   output logic                        rd_en,
   output lra_pkg::row_addr_type       rd_addr,
   input  wire lra_pkg::line_type      rd_data,
   output lra_pkg::bank_hold_type      hold,
   lra_rsp_if.source                   rsp
);
   import lra_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_EMIT
   } state_type;

   state_type    state_ff, state_in;
   job_type      job_ff, job_in;
   line_type     line_ff, line_in;
   line_idx_type ln_ff, ln_in;
   word_idx_type wd_ff, wd_in;
   chan_type     ch_ff, ch_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [6:0]   chan_ff, chan_in;
   logic [9:0]   adc_ff, adc_in;
   logic [11:0]  tot_ff, tot_in;
   logic [9:0]   toa_ff, toa_in;
   logic         last_ff, last_in;

   logic [WORD_W-1:0] cur_word;
   logic              skip, out_free, step, emit, line_end;

   assign cur_word = line_ff[wd_ff];
   assign skip     = skipped_word(ln_ff, wd_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign step     = state_ff == ST_EMIT && (skip || out_free);
   assign emit     = step && !skip;
   assign line_end = (ln_ff == LAST_LINE && wd_ff == 3'd6) || wd_ff == 3'd7;

   // the ids and stamp on the result port come from job_ff, so a new package
   // is taken only once the previous package's last beat leaves
   assign q_pop = state_ff == ST_IDLE && q_valid && out_free;

   // stored rows are fetched one line ahead; read data holds until the next read
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = {job_ff.bank, 2'd1};
      if (q_pop) begin
         rd_en   = 1'b1;
         rd_addr = {q_job.bank, 2'd0};
      end else if (state_ff == ST_PRIME) begin
         rd_en   = 1'b1;
         rd_addr = {job_ff.bank, 2'd1};
      end else if (step && line_end && ln_ff < 3'd2) begin
         rd_en   = 1'b1;
         rd_addr = {job_ff.bank, ln_ff[1:0] + 2'd2};
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      line_in  = line_ff;
      ln_in    = ln_ff;
      wd_in    = wd_ff;
      ch_in    = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               job_in   = q_job;
               ln_in    = 3'd0;
               ch_in    = '0;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            line_in  = rd_data;
            wd_in    = 3'd2;           // header and common mode skipped up front
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (step) begin
               if (emit) begin
                  ch_in = ch_ff + 6'd1;
               end
               if (line_end) begin
                  if (ln_ff == LAST_LINE) begin
                     state_in = ST_IDLE;
                  end else begin
                     ln_in   = ln_ff + 3'd1;
                     wd_in   = 3'd0;
                     line_in = (ln_ff == 3'd3) ? job_ff.words : rd_data;
                  end
               end else begin
                  wd_in = wd_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      chan_in      = chan_ff;
      adc_in       = adc_ff;
      tot_in       = tot_ff;
      toa_in       = toa_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         chan_in      = {1'b0, ch_ff} + (job_ff.half ? HALF_OFFSET : 7'd0);
         adc_in       = cur_word[29:20];
         tot_in       = decode_tot(cur_word[19:10]);
         toa_in       = cur_word[9:0];
         last_in      = ch_ff == LAST_CHAN;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff  <= job_in;
      line_ff <= line_in;
      ln_ff   <= ln_in;
      wd_ff   <= wd_in;
      ch_ff   <= ch_in;
      chan_ff <= chan_in;
      adc_ff  <= adc_in;
      tot_ff  <= tot_in;
      toa_ff  <= toa_in;
      last_ff <= last_in;
   end

   assign hold.valid = state_ff != ST_IDLE;
   assign hold.bank  = job_ff.bank;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.channel_number = chan_ff;
   assign rsp.board_out      = job_ff.board;
   assign rsp.chip_out       = job_ff.chip;
   assign rsp.stamp_out      = job_ff.stamp;
   assign rsp.adc_value      = adc_ff;
   assign rsp.tot_value      = tot_ff;
   assign rsp.toa_value      = toa_ff;
   assign rsp.last_channel   = last_ff;

   a_full_package: assert property (@(posedge clock) disable iff (reset)
      step && line_end && ln_ff == LAST_LINE |-> ch_ff == LAST_CHAN)
      else $error("package ended without 36 channels");

   a_last_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> chan_ff == 7'd35 || chan_ff == 7'd71)
      else $error("last flag on a channel that is not the last of a half");

endmodule
`default_nettype wire

>>> tb/sv/readout_line_assembler_unpacker_checker.sv
`timescale 1ns / 100ps
// Channel result checker for the readout line assembler: tracks packages, predicts, compares.
module readout_line_assembler_unpacker_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   lra_req_if          req,
   lra_rsp_if          rsp,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   import lra_pkg::*;

   localparam line_idx_type FIRST_LINE  = 3'd0;
   localparam int           PRINT_LIMIT = 40;

   typedef struct packed {
      logic [6:0]  channel;
      logic [7:0]  board;
      logic [7:0]  chip;
      logic [31:0] stamp;
      logic [9:0]  adc;
      logic [11:0] tot;
      logic [9:0]  toa;
      logic        last;
   } chan_result_type;

   chan_result_type expected_channels[$];
   line_type        stored_lines[STORED_LINES];
   line_idx_type    next_line;

   // one accepted line: store it, or unpack the package it completes
   task automatic take_line();
      line_type        words;
      line_idx_type    idx;
      logic [31:0]     cw;
      logic [9:0]      raw_tot;
      logic [6:0]      chan;
      chan_result_type r;
      idx   = req.line_index;
      words = {req.word_7, req.word_6, req.word_5, req.word_4,
               req.word_3, req.word_2, req.word_1, req.word_0};
      if (idx > LAST_LINE) begin
         return;
      end
      if (idx != FIRST_LINE && idx != next_line) begin
         next_line = FIRST_LINE;
         return;
      end
      if (idx != LAST_LINE) begin
         stored_lines[idx[1:0]] = words;
         next_line = idx + 3'd1;
         return;
      end
      next_line = FIRST_LINE;
      chan = '0;
      for (int ln = 0; ln < LINES_PER_PACKET; ln++) begin
         for (int w = 0; w < WORDS_PER_LINE; w++) begin
            // header, common mode, calibration, CRC
            if ((ln == 0 && w < 2) || (ln == 3 && w == 5) || (ln == LAST_LINE && w == 7)) begin
               continue;
            end
            cw        = (ln == LAST_LINE) ? words[w] : stored_lines[ln][w];
            raw_tot   = cw[19:10];
            r.channel = chan + (req.half_and_stamp[32] ? HALF_OFFSET : 7'd0);
            r.board   = req.board_id;
            r.chip    = req.chip_id;
            r.stamp   = req.half_and_stamp[31:0];
            r.adc     = cw[29:20];
            r.tot     = raw_tot[9] ? {raw_tot[8:0], 3'b000} : {2'b00, raw_tot};
            r.toa     = cw[9:0];
            r.last    = (chan == CHANNELS_PER_HALF - 1);
            expected_channels.push_back(r);
            chan++;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         if (fail_count < PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         end
         fail_count++;
      end
   endtask

   task automatic check_channel();
      chan_result_type want;
      if (expected_channels.size() == 0) begin
         if (fail_count < PRINT_LIMIT) begin
            $display("%0t: unexpected channel beat, expected none, got channel %0d adc 0x%0h",
                     $time, rsp.channel_number, rsp.adc_value);
         end
         fail_count++;
         return;
      end
      want = expected_channels.pop_front();
      check_field("channel_number", 32'(want.channel), 32'(rsp.channel_number));
      check_field("board_out", 32'(want.board), 32'(rsp.board_out));
      check_field("chip_out", 32'(want.chip), 32'(rsp.chip_out));
      check_field("stamp_out", want.stamp, rsp.stamp_out);
      check_field("adc_value", 32'(want.adc), 32'(rsp.adc_value));
      check_field("tot_value", 32'(want.tot), 32'(rsp.tot_value));
      check_field("toa_value", 32'(want.toa), 32'(rsp.toa_value));
      check_field("last_channel", 32'(want.last), 32'(rsp.last_channel));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         next_line = FIRST_LINE;
         expected_channels.delete();
      end else begin
         if (req.valid && req.ready) begin
            take_line();
         end
         if (rsp.valid && rsp.ready) begin
            check_channel();
         end
      end
      pending_count = expected_channels.size();
   end

endmodule

>>> tb/sv/readout_line_assembler_unpacker_tb.sv
`timescale 1ns / 100ps
// Testbench top for the readout line assembler: clock, reset, line stimulus and verdict.
module readout_line_assembler_unpacker_tb;
   import lra_pkg::*;

   localparam line_idx_type TOP_INDEX    = 3'd7;   // highest index the field can carry
   localparam int           RANDOM_LINES = 75;     // random lines with index 0..4
   localparam int           CALM_LINES   = 20;     // tail of the run with no idling
   localparam int           DRAIN_CYCLES = 64;
   localparam int unsigned  CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset;
   bit          calm;          // set for the last part of the run: no gaps, no stalls
   int unsigned lines_sent;    // lines with a meaningful index, drives the random part
   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned pending_count;

   lra_req_if req();
   lra_rsp_if rsp();

   readout_line_assembler_unpacker u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   readout_line_assembler_unpacker_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: runs of ready, broken by stall bursts. Every assignment is
   // followed by a clock edge before the next, so ready never gets two updates
   // in one step.
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(posedge clock);
         end
      end
   end

   function automatic line_type random_line();
      line_type words;
      for (int w = 0; w < WORDS_PER_LINE; w++) begin
         words[w] = $urandom;
      end
      return words;
   endfunction

   // one line beat; an optional gap burst first, then hold valid until ready
   task automatic send_line(input line_idx_type idx, input line_type words,
                            input logic [7:0] board, input logic [7:0] chip,
                            input logic [32:0] half_stamp);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req.valid          <= 1'b1;
      req.line_index     <= idx;
      req.word_0         <= words[0];
      req.word_1         <= words[1];
      req.word_2         <= words[2];
      req.word_3         <= words[3];
      req.word_4         <= words[4];
      req.word_5         <= words[5];
      req.word_6         <= words[6];
      req.word_7         <= words[7];
      req.board_id       <= board;
      req.chip_id        <= chip;
      req.half_and_stamp <= half_stamp;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (idx <= LAST_LINE) begin
         lines_sent++;
      end
   endtask

   // ids and stamp change on every line: only those of line 4 may show up
   task automatic send_random_line(input line_idx_type idx);
      logic [32:0] half_stamp;
      half_stamp[31:0] = $urandom;
      half_stamp[32]   = 1'($urandom_range(0, 1));
      send_line(idx, random_line(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                half_stamp);
   endtask

   task automatic send_package(input line_type fill, input logic [7:0] board,
                               input logic [7:0] chip, input logic [32:0] half_stamp);
      for (int ln = 0; ln <= LAST_LINE; ln++) begin
         send_line(line_idx_type'(ln), fill, board, chip, half_stamp);
      end
   endtask

   initial begin
      // ignored indexes then a stray line 4; a restart at line 0 in mid run with an
      // ignored line before the completing one; a skipped line breaking the run
      line_idx_type odd_order[15] = '{3'd5, 3'd6, 3'd7, 3'd4,
                                      3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd4,
                                      3'd0, 3'd2, 3'd4};
      int unsigned  pick;
      int unsigned  cut;

      reset              <= 1'b1;
      req.valid          <= 1'b0;
      req.line_index     <= '0;
      req.word_0         <= '0;
      req.word_1         <= '0;
      req.word_2         <= '0;
      req.word_3         <= '0;
      req.word_4         <= '0;
      req.word_5         <= '0;
      req.word_6         <= '0;
      req.word_7         <= '0;
      req.board_id       <= '0;
      req.chip_id        <= '0;
      req.half_and_stamp <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes: all-zero package on half 0, all-ones package on half 1
      // (all ones also gives a TOT with bit 9 set on every channel)
      send_package('0, 8'h00, 8'h00, 33'h0);
      send_package('1, 8'hFF, 8'hFF, {33{1'b1}});
      foreach (odd_order[i]) begin
         send_random_line(odd_order[i]);
      end

      // random part: mostly whole packages with random content, some with an
      // ignored line slipped in; the rest broken runs and lone noise lines
      lines_sent = 0;
      while (lines_sent < RANDOM_LINES) begin
         calm = (lines_sent + CALM_LINES >= RANDOM_LINES);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            for (int ln = 0; ln <= LAST_LINE; ln++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_random_line(line_idx_type'($urandom_range(LAST_LINE + 1, TOP_INDEX)));
               end
               send_random_line(line_idx_type'(ln));
            end
         end else if (pick < 9) begin
            cut = $urandom_range(1, LAST_LINE);
            for (int ln = 0; ln < cut; ln++) begin
               send_random_line(line_idx_type'(ln));
            end
            send_random_line(line_idx_type'($urandom_range(1, LAST_LINE)));
         end else begin
            send_random_line(line_idx_type'($urandom_range(0, TOP_INDEX)));
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // catch stray beats after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
